>>> src/mbrf_pkg.sv
// Shared types, constants and CRC helpers for the Modbus RTU read request framer.
// Used by the framer and its checker; depends on nothing else.
package mbrf_pkg;

   // Frame layout.
   localparam int FrameLen = 8;
   localparam int CrcSpan  = 6;
   localparam int IdxW     = $clog2(FrameLen);

   localparam logic [7:0]  FuncReadInput = 8'h04;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;
   localparam logic [15:0] CrcLsb        = 16'h0001;

   // Byte positions within the frame, in transmit order.
   localparam logic [IdxW-1:0] ByteAddr    = IdxW'(0);
   localparam logic [IdxW-1:0] ByteFunc    = IdxW'(1);
   localparam logic [IdxW-1:0] ByteStartHi = IdxW'(2);
   localparam logic [IdxW-1:0] ByteStartLo = IdxW'(3);
   localparam logic [IdxW-1:0] ByteCountHi = IdxW'(4);
   localparam logic [IdxW-1:0] ByteCountLo = IdxW'(5);
   localparam logic [IdxW-1:0] ByteCrcLo   = IdxW'(6);
   localparam logic [IdxW-1:0] ByteCrcHi   = IdxW'(7);

   // One request beat.
   typedef struct packed {
      logic [7:0]  slave_address;
      logic [15:0] start_address;
      logic [15:0] register_count;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // Request fields plus the running CRC, carried down the pipeline.
   typedef struct packed {
      logic [7:0]  slave_address;
      logic [15:0] start_address;
      logic [15:0] register_count;
      logic [15:0] crc;
   } stage_type;

   // CRC-16/MODBUS update over one byte, bit by bit, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] acc;
      acc = crc_in ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if ((acc & CrcLsb) != 16'h0000) begin
            acc = (acc >> 1) ^ CrcPoly;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

   // Frame byte at a given position, taken from the carried fields.
   function automatic logic [7:0] byte_at(input stage_type s,
                                          input logic [IdxW-1:0] idx);
      logic [7:0] b;
      case (idx)
         ByteAddr:    b = s.slave_address;
         ByteFunc:    b = FuncReadInput;
         ByteStartHi: b = s.start_address[15:8];
         ByteStartLo: b = s.start_address[7:0];
         ByteCountHi: b = s.register_count[15:8];
         ByteCountLo: b = s.register_count[7:0];
         ByteCrcLo:   b = s.crc[7:0];
         ByteCrcHi:   b = s.crc[15:8];
         default:     b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> src/modbus_rtu_read_request_framer.sv
// Modbus RTU Read Input Registers request framer: CRC pipeline and byte serializer.
// Depends on mbrf_pkg for beat types, frame constants and the CRC byte update.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | mbrf_pkg::req_type (address, start, count)
//   rsp     | out       | rsp_valid/rsp_stall | mbrf_pkg::rsp_type (frame byte, last flag)
//
// The serializer sends one frame byte per cycle while rsp_stall stays low and loads
// the next frame as the last byte of the current one leaves.
// The CRC runs in six register stages, one frame byte each; a request beat passes
// through all six, then the serializer, before its first byte is on rsp.
// Synchronous reset clears all valid bits; payload registers are not reset.
// rsp_stall holds the current byte and backs the pipeline up stage by stage.
module modbus_rtu_read_request_framer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mbrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mbrf_pkg::rsp_type rsp_data
);

   localparam int Stages = mbrf_pkg::CrcSpan;

   // CRC pipeline registers.
   mbrf_pkg::stage_type stage_ff [Stages];
   mbrf_pkg::stage_type stage_in [Stages];
   logic [Stages-1:0]   valid_ff;
   logic [Stages-1:0]   take;

   // Serializer registers.
   mbrf_pkg::stage_type      frame_ff;
   logic                     frame_valid_ff;
   logic [mbrf_pkg::IdxW-1:0] idx_ff;
   logic [mbrf_pkg::IdxW-1:0] idx_in;

   logic rsp_done;
   logic is_last;
   logic frame_take;

   // Output beat comes straight from the serializer registers.
   assign is_last            = (idx_ff == mbrf_pkg::ByteCrcHi);
   assign rsp_valid          = frame_valid_ff;
   assign rsp_data.frame_byte = mbrf_pkg::byte_at(frame_ff, idx_ff);
   assign rsp_data.last_byte  = is_last;
   assign rsp_done           = frame_valid_ff && !rsp_stall;

   // The serializer loads a new frame when it is empty or its last byte leaves.
   assign frame_take = !frame_valid_ff || (rsp_done && is_last);

   // A stage loads when it is empty or its contents move on this cycle.
   always_comb begin
      take[Stages-1] = !valid_ff[Stages-1] || frame_take;
      for (int i = Stages - 2; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
   end

   assign req_stall = !take[0];

   // Next stage contents: each stage folds one more frame byte into the CRC.
   always_comb begin
      stage_in[0].slave_address  = req_data.slave_address;
      stage_in[0].start_address  = req_data.start_address;
      stage_in[0].register_count = req_data.register_count;
      stage_in[0].crc = mbrf_pkg::crc_byte(mbrf_pkg::CrcInit, req_data.slave_address);
      for (int i = 1; i < Stages; i++) begin
         stage_in[i]     = stage_ff[i-1];
         stage_in[i].crc = mbrf_pkg::crc_byte(stage_ff[i-1].crc,
            mbrf_pkg::byte_at(stage_ff[i-1], mbrf_pkg::IdxW'(i)));
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < Stages; i++) begin
            if (take[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      for (int i = 0; i < Stages; i++) begin
         if (take[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Byte index steps on every taken beat and restarts with a new frame.
   always_comb begin
      idx_in = idx_ff;
      if (frame_take) begin
         idx_in = mbrf_pkg::ByteAddr;
      end else if (rsp_done) begin
         idx_in = idx_ff + mbrf_pkg::IdxW'(1);
      end
   end

   // Serializer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         idx_ff         <= mbrf_pkg::ByteAddr;
      end else begin
         if (frame_take) begin
            frame_valid_ff <= valid_ff[Stages-1];
         end
         idx_ff <= idx_in;
      end
   end

   // Serializer payload.
   always_ff @(posedge clock) begin
      if (frame_take) begin
         frame_ff <= stage_ff[Stages-1];
      end
   end

endmodule

>>> src/mbrf_checker.sv
// Port-level checks for the Modbus RTU read request framer, bound to its top level.
// Depends on mbrf_pkg for the beat types.
module mbrf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mbrf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mbrf_pkg::rsp_type rsp_data
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // The beat after a taken last byte is not itself a last byte.
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_byte |=> !(rsp_valid && rsp_data.last_byte))
      else $error("two last bytes in a row");

   // With no result pending the pipeline is drained enough to take a request.
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no result is pending");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind modbus_rtu_read_request_framer mbrf_checker u_mbrf_checker (.*);
